FILE: rtl/core/lirr_pkg.sv
// Shared constants, types and tables of the linear interpolation resample reader.
`default_nettype none

package lirr_pkg;

  // Sizing
  localparam int unsigned BUFFER_SAMPLES = 1024;
  localparam int unsigned MAX_CHANNELS   = 8;
  localparam int unsigned FRAC_BITS      = 16;
  localparam int unsigned QUEUE_DEPTH    = 2;

  // Fixed field widths
  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned CH_OUT_W       = 3;
  localparam int unsigned CHANS_CFG_W    = 4;
  localparam int unsigned FRAMES_CFG_W   = 11;
  localparam int unsigned RATE_W         = 24;
  localparam int unsigned CFG_DATA_W     = 24;
  localparam int unsigned CFG_IDX_W      = 2;

  // Derived widths
  localparam int unsigned STORE_DEPTH = BUFFER_SAMPLES + MAX_CHANNELS;
  localparam int unsigned AW     = $clog2(STORE_DEPTH);
  localparam int unsigned FW     = $clog2(BUFFER_SAMPLES + 1);
  localparam int unsigned CW     = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned IW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned PW     = FW + FRAC_BITS;
  localparam int unsigned SUM_W  = ((PW > RATE_W) ? PW : RATE_W) + 1;
  localparam int unsigned MOD_W  = SUM_W - FRAC_BITS;
  localparam int unsigned CNT_W  = $clog2(MOD_W);
  localparam int unsigned PRODW  = FRAC_BITS + SAMPLE_W + 2;
  localparam int unsigned FCMP_W = (FW > FRAMES_CFG_W) ? FW : FRAMES_CFG_W;
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_BUFFER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_STEP         = 2'd2;

  // Configuration reset values
  localparam logic [CHANS_CFG_W-1:0]  RST_CHANNEL_COUNT     = 4'd1;
  localparam logic [FRAMES_CFG_W-1:0] RST_FRAMES_PER_BUFFER = 11'd1024;
  localparam logic [RATE_W-1:0]       RST_RATE_STEP         = 24'd65536;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_TICK  = 1'b1
  } action_e;

  typedef struct packed {
    action_e                     action;
    logic signed [SAMPLE_W-1:0]  sample;
  } cmd_t;

  // Clamped configuration as the back end sees it
  typedef struct packed {
    logic [CW-1:0]     chans;
    logic [FW-1:0]     frames;
    logic [FW-1:0]     used;
    logic [RATE_W-1:0] rate;
  } eff_t;

  typedef struct packed {
    logic                we;
    logic [AW-1:0]       waddr;
    logic [SAMPLE_W-1:0] wdata;
    logic [AW-1:0]       raddr;
  } ram_req_t;

  // Largest frame count for each channel count (entry k holds frames for k+1 channels)
  typedef logic [FW-1:0] cap_tbl_t [MAX_CHANNELS];

  function automatic cap_tbl_t build_frame_caps();
    cap_tbl_t    tbl;
    int unsigned rem;
    int unsigned quo;
    for (int unsigned k = 1; k <= MAX_CHANNELS; k++) begin
      rem = 0;
      quo = 0;
      for (int b = 31; b >= 0; b--) begin
        rem = (rem << 1) | ((BUFFER_SAMPLES >> b) & 1);
        quo = quo << 1;
        if (rem >= k) begin
          rem = rem - k;
          quo = quo | 1;
        end
      end
      tbl[k-1] = FW'(quo);
    end
    return tbl;
  endfunction

  localparam cap_tbl_t FRAME_CAP = build_frame_caps();

endpackage

`default_nettype wire

FILE: rtl/core/lirr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module lirr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1032
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/lirr_front.sv
// Front end: accepts input items, classifies them and holds them in a short queue.
`default_nettype none

module lirr_front
  import lirr_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic                       action_i,
  input  wire logic signed [SAMPLE_W-1:0] sample_in_i,
  output logic                            cmd_valid_o,
  output cmd_t                            cmd_o,
  input  wire logic                       cmd_pop_i
);

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;
  cmd_t              cmd_in;

  assign in_stall_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = entry_q[rd_ptr_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  // Ticks carry no sample: drop it
  always_comb begin
    cmd_in.action = action_i ? ACT_TICK : ACT_WRITE;
    cmd_in.sample = action_i ? '0 : sample_in_i;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_q + 1'b1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_q + 1'b1);
    end
    unique case ({push, pop})
      2'b10:   count_d = QCNT_W'(count_q + 1'b1);
      2'b01:   count_d = QCNT_W'(count_q - 1'b1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lirr_back.sv
// Back end: stores samples, advances the read position and interpolates each channel.
`default_nettype none

module lirr_back
  import lirr_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire eff_t                  eff_i,
  input  wire logic                  cmd_valid_i,
  input  wire cmd_t                  cmd_i,
  output logic                       cmd_pop_o,
  output ram_req_t                   ram_req_o,
  input  wire logic [SAMPLE_W-1:0]   ram_rdata_i,
  input  wire logic                  out_stall_i,
  output logic                       out_valid_o,
  output logic signed [SAMPLE_W-1:0] sample_out_o,
  output logic [CH_OUT_W-1:0]        channel_index_o,
  output logic                       last_o,
  output logic                       refill_request_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WRITE = 4'd1;
  localparam logic [3:0] S_GUARD = 4'd2;
  localparam logic [3:0] S_MOD   = 4'd3;
  localparam logic [3:0] S_ADV   = 4'd4;
  localparam logic [3:0] S_BASE  = 4'd5;
  localparam logic [3:0] S_RD0   = 4'd6;
  localparam logic [3:0] S_RD1   = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]                 state_q, state_d;
  logic [FW-1:0]              wi_q, wi_d;
  logic [PW-1:0]              pos_q, pos_d;
  logic                       out_valid_q, out_valid_d;

  logic [SAMPLE_W-1:0]        smp_q, smp_d;
  logic [AW-1:0]              gaddr_q, gaddr_d;
  logic [MOD_W-1:0]           modv_q, modv_d;
  logic [FW-1:0]              r_q, r_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       phase_q, phase_d;
  logic [FRAC_BITS-1:0]       frac_q, frac_d;
  logic [FRAC_BITS-1:0]       nfrac_q, nfrac_d;
  logic [FW-1:0]              n_q, n_d;
  logic                       refill_q, refill_d;
  logic [AW-1:0]              addr0_q, addr0_d;
  logic [IW-1:0]              ch_q, ch_d;
  logic signed [SAMPLE_W-1:0] x0_q, x0_d;
  logic signed [PRODW-1:0]    prod_q, prod_d;

  logic signed [SAMPLE_W-1:0] out_smp_q, out_smp_d;
  logic [CH_OUT_W-1:0]        out_ch_q, out_ch_d;
  logic                       out_last_q, out_last_d;
  logic                       out_refill_q, out_refill_d;

  logic                       out_free;
  logic [FW:0]                r_sh;
  logic [FW-1:0]              r_nx;
  logic [FW-1:0]              wi_eff;
  logic [FW-1:0]              wi_inc;
  logic [SUM_W-1:0]           adv_sum;
  logic [MOD_W-1:0]           adv_int;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [PRODW-1:0]    y_full;
  logic                       ch_last;

  assign out_free = !out_valid_q || !out_stall_i;

  // One restoring remainder step against the frame count
  assign r_sh = {r_q, modv_q[MOD_W-1]};
  assign r_nx = (r_sh >= (FW+1)'(eff_i.frames)) ? FW'(r_sh - (FW+1)'(eff_i.frames))
                                                  : FW'(r_sh);

  assign wi_eff  = (wi_q >= eff_i.used) ? '0 : wi_q;
  assign wi_inc  = FW'(wi_eff + 1'b1);
  assign adv_sum = SUM_W'({n_q, frac_q}) + SUM_W'(eff_i.rate);
  assign adv_int = adv_sum[SUM_W-1:FRAC_BITS];
  assign diff    = (SAMPLE_W+1)'($signed(ram_rdata_i)) - (SAMPLE_W+1)'(x0_q);
  assign y_full  = (prod_q >>> FRAC_BITS) + PRODW'(x0_q);
  assign ch_last = (CW'(ch_q) == CW'(eff_i.chans - 1'b1));

  always_comb begin
    state_d      = state_q;
    wi_d         = wi_q;
    pos_d        = pos_q;
    out_valid_d  = out_valid_q;
    smp_d        = smp_q;
    gaddr_d      = gaddr_q;
    modv_d       = modv_q;
    r_d          = r_q;
    cnt_d        = cnt_q;
    phase_d      = phase_q;
    frac_d       = frac_q;
    nfrac_d      = nfrac_q;
    n_d          = n_q;
    refill_d     = refill_q;
    addr0_d      = addr0_q;
    ch_d         = ch_q;
    x0_d         = x0_q;
    prod_d       = prod_q;
    out_smp_d    = out_smp_q;
    out_ch_d     = out_ch_q;
    out_last_d   = out_last_q;
    out_refill_d = out_refill_q;
    cmd_pop_o    = 1'b0;
    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = AW'(wi_eff);
    ram_req_o.wdata = smp_q;
    ram_req_o.raddr = addr0_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.action == ACT_TICK) begin
            modv_d  = MOD_W'(pos_q[PW-1:FRAC_BITS]);
            frac_d  = pos_q[FRAC_BITS-1:0];
            r_d     = '0;
            cnt_d   = CNT_W'(MOD_W - 1);
            phase_d = 1'b0;
            state_d = S_MOD;
          end else begin
            smp_d   = cmd_i.sample;
            state_d = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        ram_req_o.we = 1'b1;
        gaddr_d = AW'(wi_eff) + AW'(eff_i.chans);
        wi_d    = (wi_inc >= eff_i.used) ? '0 : wi_inc;
        // The last frame also lands in the guard frame after it
        state_d = (wi_eff >= FW'(eff_i.used - FW'(eff_i.chans))) ? S_GUARD : S_IDLE;
      end
      S_GUARD: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = gaddr_q;
        state_d = S_IDLE;
      end
      S_MOD: begin
        r_d    = r_nx;
        modv_d = MOD_W'(modv_q << 1);
        cnt_d  = CNT_W'(cnt_q - 1'b1);
        if (cnt_q == '0) begin
          if (!phase_q) begin
            n_d     = r_nx;
            state_d = S_ADV;
          end else begin
            pos_d   = {r_nx, nfrac_q};
            state_d = S_BASE;
          end
        end
      end
      S_ADV: begin
        nfrac_d  = adv_sum[FRAC_BITS-1:0];
        refill_d = (adv_int >= MOD_W'(eff_i.frames));
        modv_d   = adv_int;
        r_d      = '0;
        cnt_d    = CNT_W'(MOD_W - 1);
        phase_d  = 1'b1;
        state_d  = S_MOD;
      end
      S_BASE: begin
        addr0_d = AW'(n_q * eff_i.chans);
        ch_d    = '0;
        state_d = S_RD0;
      end
      S_RD0: begin
        state_d = S_RD1;
      end
      S_RD1: begin
        ram_req_o.raddr = AW'(addr0_q + AW'(eff_i.chans));
        x0_d    = $signed(ram_rdata_i);
        state_d = S_MUL;
      end
      S_MUL: begin
        prod_d  = $signed({1'b0, frac_q}) * diff;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_smp_d    = y_full[SAMPLE_W-1:0];
          out_ch_d     = CH_OUT_W'(ch_q);
          out_last_d   = ch_last;
          out_refill_d = refill_q;
          if (ch_last) begin
            state_d = S_IDLE;
          end else begin
            ch_d    = IW'(ch_q + 1'b1);
            addr0_d = AW'(addr0_q + 1'b1);
            state_d = S_RD0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wi_q        <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wi_q        <= wi_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q        <= smp_d;
    gaddr_q      <= gaddr_d;
    modv_q       <= modv_d;
    r_q          <= r_d;
    cnt_q        <= cnt_d;
    phase_q      <= phase_d;
    frac_q       <= frac_d;
    nfrac_q      <= nfrac_d;
    n_q          <= n_d;
    refill_q     <= refill_d;
    addr0_q      <= addr0_d;
    ch_q         <= ch_d;
    x0_q         <= x0_d;
    prod_q       <= prod_d;
    out_smp_q    <= out_smp_d;
    out_ch_q     <= out_ch_d;
    out_last_q   <= out_last_d;
    out_refill_q <= out_refill_d;
  end

  assign out_valid_o      = out_valid_q;
  assign sample_out_o     = out_smp_q;
  assign channel_index_o  = out_ch_q;
  assign last_o           = out_last_q;
  assign refill_request_o = out_refill_q;

endmodule

`default_nettype wire

FILE: rtl/core/linear_interp_resample_reader.sv
// Top level of the linear interpolation resample reader.
//
// Input channel (in_valid_i / in_stall_o): an item with action_i low stores
// sample_in_i as the next interleaved sample of the frame buffer; an item with
// action_i high is a tick that emits one interpolated sample per channel on the
// output channel (out_valid_o / out_stall_i), last_o marking the final channel
// and refill_request_o set on every sample of a tick whose read position wrapped.
// Configuration is written through cfg_valid_i / cfg_ready_o (always ready) with
// cfg_index_i selecting channel count, frames per buffer or rate step.
// Items pass a two-entry queue into the back end, which handles one at a time.
// A write item passes the write state in the back end, and on the last frame
// also the guard state (guard copy). A tick first does its position arithmetic,
// bound by the bit-serial remainder against the frame count, then handles each
// channel in turn (two RAM reads, multiply, output).
// Reset clears read position, write index and queue and restores the
// configuration defaults; buffer contents are undefined until written.
// While the receiver stalls, the held result stays put, the back end waits and
// the queue keeps taking items until it is full.
`default_nettype none

module linear_interp_resample_reader
  import lirr_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        action_i,
  input  wire logic signed [SAMPLE_W-1:0]  sample_in_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic signed [SAMPLE_W-1:0]       sample_out_o,
  output logic [CH_OUT_W-1:0]              channel_index_o,
  output logic                             last_o,
  output logic                             refill_request_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]       cfg_data_i
);

  logic [CHANS_CFG_W-1:0]  chan_q;
  logic [FRAMES_CFG_W-1:0] frames_q;
  logic [RATE_W-1:0]       rate_q;
  eff_t                    eff_d, eff_q;
  logic [FW-1:0]           cap;
  logic [FCMP_W-1:0]       frames_lim;

  logic                    cmd_valid;
  cmd_t                    cmd;
  logic                    cmd_pop;
  ram_req_t                ram_req;
  logic [SAMPLE_W-1:0]     ram_rdata;

  // Configuration registers; writes beyond the list are taken and ignored
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q   <= RST_CHANNEL_COUNT;
      frames_q <= RST_FRAMES_PER_BUFFER;
      rate_q   <= RST_RATE_STEP;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_CHANNEL_COUNT:     chan_q   <= cfg_data_i[CHANS_CFG_W-1:0];
        CFG_FRAMES_PER_BUFFER: frames_q <= cfg_data_i[FRAMES_CFG_W-1:0];
        CFG_RATE_STEP:         rate_q   <= cfg_data_i[RATE_W-1:0];
        default:               chan_q   <= chan_q;
      endcase
    end
  end

  // Clamp channel and frame counts; register the result once so the back end
  // sees short paths. Items reach the back end no earlier than this register.
  always_comb begin
    if (chan_q == '0) begin
      eff_d.chans = CW'(1);
    end else if ({1'b0, chan_q} > (CHANS_CFG_W+1)'(MAX_CHANNELS)) begin
      eff_d.chans = CW'(MAX_CHANNELS);
    end else begin
      eff_d.chans = CW'(chan_q);
    end
    cap = FRAME_CAP[IW'(eff_d.chans - 1'b1)];
    frames_lim = (FCMP_W'(frames_q) > FCMP_W'(cap)) ? FCMP_W'(cap) : FCMP_W'(frames_q);
    eff_d.frames = (frames_lim < FCMP_W'(2)) ? FW'(2) : FW'(frames_lim);
    eff_d.used   = FW'(eff_d.frames * eff_d.chans);
    eff_d.rate   = rate_q;
  end

  always_ff @(posedge clk_i) begin
    eff_q <= eff_d;
  end

  lirr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .sample_in_i (sample_in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  lirr_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  lirr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .eff_i            (eff_q),
    .cmd_valid_i      (cmd_valid),
    .cmd_i            (cmd),
    .cmd_pop_o        (cmd_pop),
    .ram_req_o        (ram_req),
    .ram_rdata_i      (ram_rdata),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .sample_out_o     (sample_out_o),
    .channel_index_o  (channel_index_o),
    .last_o           (last_o),
    .refill_request_o (refill_request_o)
  );

`ifndef SYNTH
  // The back end only takes an item that the queue actually holds
  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("back end popped an empty queue");

  // Taking a new item never coincides with a store write
  a_pop_not_writing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !ram_req.we)
    else $error("item taken while a store write is in flight");

  // Store writes, guard frame included, stay inside the buffer
  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req.we |-> ({1'b0, ram_req.waddr} < (AW+1)'(STORE_DEPTH)))
    else $error("store write beyond buffer");

  // Every result belongs to a channel in use
  a_channel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CW'(channel_index_o) < eff_q.chans))
    else $error("result for a channel not in use");
`endif

endmodule

`default_nettype wire
